// ===== src/brl_pkg.sv =====
`default_nettype none
package brl_pkg;

	localparam int CoordW = 6;
	localparam int SizeW  = 7;
	localparam int IndexW = 12;
	localparam int ColorW = 24;
	localparam int ErrW   = 9;

	localparam logic [0:0] RegFrameWidth  = 1'b0;
	localparam logic [0:0] RegFrameHeight = 1'b1;

	typedef struct packed {
		logic [CoordW-1:0] start_x;
		logic [CoordW-1:0] start_y;
		logic [CoordW-1:0] end_x;
		logic [CoordW-1:0] end_y;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
	} in_word_t;

	typedef struct packed {
		logic [CoordW-1:0] pixel_x;
		logic [CoordW-1:0] pixel_y;
		logic [IndexW-1:0] pixel_index;
		logic [ColorW-1:0] packed_color;
		logic              write_enable;
		logic              last_pixel;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic step;
	} brl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last;
	} brl_sts_t;

endpackage
`default_nettype wire

// ===== src/bresenham_line_rasterizer_top.sv =====
// channel | dir | valid     | stall     | word
// line    | in  | in_valid  | in_stall  | in_word  (in_word_t: endpoints, colour)
// pixel   | out | out_valid | out_stall | out_word (out_word_t: one pixel)
// config  | in  | APB: psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A line of n pixels (n = major span + 1, 1 to 64) is accepted, set up, then walked
// in n steps, one step a cycle while no output stall holds the walk loop.
// A new line is accepted as soon as the previous last pixel is in the output
// register, even while that pixel still waits.
// Out stalls hold the walk; in_stall is high from accept until the last step.
// Reset clears control state; frame registers reset to 64 by 64.
`default_nettype none
module bresenham_line_rasterizer_top
	import brl_pkg::*;
#(
	parameter int MAX_DIM = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_word_t    in_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_word_t        out_word,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [SizeW-1:0] frame_width_q, frame_height_q;
	brl_cmd_t         cmd;
	brl_sts_t         sts;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= SizeW'(64);
			frame_height_q <= SizeW'(64);
		end else if (wr_en) begin
			if (paddr[2] == RegFrameWidth) begin
				frame_width_q <= pwdata[SizeW-1:0];
			end else begin
				frame_height_q <= pwdata[SizeW-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == RegFrameWidth) ? 32'(frame_width_q) : 32'(frame_height_q);

	brl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	brl_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_word      (in_word),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_word     (out_word)
	);

`ifndef SYNTH
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.setup, cmd.step}))
		else $error("controller commands overlap");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && cmd.setup)
		else $error("line accepted without setup");

	a_clip_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.write_enable |-> out_word.pixel_index == '0)
		else $error("clipped pixel carries an index");

	a_step_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !out_valid || !out_stall)
		else $error("pixel overwrote a waiting word");
`endif

endmodule
`default_nettype wire

// ===== src/brl_ctrl.sv =====
`default_nettype none
module brl_ctrl
	import brl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire brl_sts_t sts,
	output brl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_WALK  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (sts.out_free) begin
					cmd.step = 1'b1;
					if (sts.last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== src/brl_datapath.sv =====
`default_nettype none
module brl_datapath
	import brl_pkg::*;
#(
	parameter int MAX_DIM = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire in_word_t         in_word,
	input  wire logic [SizeW-1:0] frame_width,
	input  wire logic [SizeW-1:0] frame_height,
	input  wire brl_cmd_t         cmd,
	output brl_sts_t              sts,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_word_t             out_word
);

	localparam logic [CoordW-1:0] CoordMax = CoordW'(MAX_DIM - 1);

	function automatic logic [CoordW-1:0] clamp(input logic [CoordW-1:0] v);
		clamp = (v > CoordMax) ? CoordMax : v;
	endfunction

	in_word_t                 in_q;
	logic [CoordW-1:0]        major_pos_q, minor_pos_q, major_end_q;
	logic [CoordW-1:0]        dmaj_q, dmin_q;
	logic signed [ErrW-1:0]   err_q;
	logic                     neg_q, steep_q;
	logic [ColorW-1:0]        held_color_q;
	logic                     out_valid_q;
	out_word_t                out_word_q;

	// setup
	logic [CoordW-1:0] x0, y0, x1, y1, adx, ady;
	logic [CoordW-1:0] a0, b0, a1, b1, ma0, mi0, ma1, mi1;
	logic              steep, swap, neg;
	logic [CoordW-1:0] dmaj, dmin;
	logic signed [ErrW-1:0] err_init;

	always_comb begin
		x0    = clamp(in_q.start_x);
		y0    = clamp(in_q.start_y);
		x1    = clamp(in_q.end_x);
		y1    = clamp(in_q.end_y);
		adx   = (x1 > x0) ? x1 - x0 : x0 - x1;
		ady   = (y1 > y0) ? y1 - y0 : y0 - y1;
		steep = !(ady < adx);
		a0    = steep ? y0 : x0;
		b0    = steep ? x0 : y0;
		a1    = steep ? y1 : x1;
		b1    = steep ? x1 : y1;
		swap  = a0 > a1;
		ma0   = swap ? a1 : a0;
		mi0   = swap ? b1 : b0;
		ma1   = swap ? a0 : a1;
		mi1   = swap ? b0 : b1;
		dmaj  = ma1 - ma0;
		neg   = mi0 > mi1;
		dmin  = neg ? mi0 - mi1 : mi1 - mi0;
		err_init = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
	end

	// walk
	logic [CoordW-1:0]         px, py;
	logic                      in_frame, last;
	logic [CoordW+SizeW:0]     lin;
	out_word_t                 pix;
	logic signed [ErrW-1:0]    inc_diag, inc_flat;

	always_comb begin
		px       = steep_q ? minor_pos_q : major_pos_q;
		py       = steep_q ? major_pos_q : minor_pos_q;
		in_frame = ({1'b0, px} < frame_width) && ({1'b0, py} < frame_height);
		last     = major_pos_q >= major_end_q;
		lin      = (CoordW+SizeW+1)'(py) * (CoordW+SizeW+1)'(frame_width)
			+ (CoordW+SizeW+1)'(px);
		inc_diag = $signed({2'b00, dmin_q, 1'b0}) - $signed({2'b00, dmaj_q, 1'b0});
		inc_flat = $signed({2'b00, dmin_q, 1'b0});
		pix.pixel_x      = px;
		pix.pixel_y      = py;
		pix.pixel_index  = in_frame ? lin[IndexW-1:0] : '0;
		pix.packed_color = held_color_q;
		pix.write_enable = in_frame;
		pix.last_pixel   = last;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_word;
		end
		if (cmd.setup) begin
			major_pos_q  <= ma0;
			minor_pos_q  <= mi0;
			major_end_q  <= ma1;
			dmaj_q       <= dmaj;
			dmin_q       <= dmin;
			err_q        <= err_init;
			neg_q        <= neg;
			steep_q      <= steep;
			held_color_q <= {in_q.red, in_q.green, in_q.blue};
		end else if (cmd.step) begin
			if (err_q > 0) begin
				minor_pos_q <= neg_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
				err_q       <= err_q + inc_diag;
			end else begin
				err_q <= err_q + inc_flat;
			end
			if (!last) begin
				major_pos_q <= major_pos_q + 1'b1;
			end
		end
		if (cmd.step) begin
			out_word_q <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.last     = last;
	assign out_valid    = out_valid_q;
	assign out_word     = out_word_q;

endmodule
`default_nettype wire

// ===== bench/brl_checker.sv =====
`default_nettype none
module brl_checker
	import brl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire in_word_t    in_word,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire out_word_t   out_word,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic [31:0] prdata,
	input  wire logic        pready,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] AddrWidth  = {RegFrameWidth, 2'b00};
	localparam logic [2:0] AddrHeight = {RegFrameHeight, 2'b00};

	logic [SizeW-1:0] frame_w;
	logic [SizeW-1:0] frame_h;
	out_word_t        expected_pixels[$];

	task automatic note_mismatch(string what, logic [63:0] exp, logic [63:0] got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s mismatch: expected %h got %h", $realtime, what, exp, got);
	endtask

	// walk one line and queue every pixel it produces
	function automatic void rasterize_line(in_word_t w);
		int x0, y0, x1, y1, adx, ady;
		int ma0, mi0, ma1, mi1, dmaj, dmin, t, err, n, px, py;
		bit steep, neg, last, in_frame;
		logic [6:0] maj, mnr, mend;
		out_word_t pix;

		x0 = (w.start_x > 63) ? 63 : w.start_x;
		y0 = (w.start_y > 63) ? 63 : w.start_y;
		x1 = (w.end_x > 63) ? 63 : w.end_x;
		y1 = (w.end_y > 63) ? 63 : w.end_y;
		adx = (x1 > x0) ? x1 - x0 : x0 - x1;
		ady = (y1 > y0) ? y1 - y0 : y0 - y1;
		steep = !(ady < adx);
		if (steep) begin
			ma0 = y0; mi0 = x0; ma1 = y1; mi1 = x1;
		end else begin
			ma0 = x0; mi0 = y0; ma1 = x1; mi1 = y1;
		end
		if (ma0 > ma1) begin
			t = ma0; ma0 = ma1; ma1 = t;
			t = mi0; mi0 = mi1; mi1 = t;
		end
		dmaj = ma1 - ma0;
		dmin = mi1 - mi0;
		neg = 1'b0;
		if (dmin < 0) begin
			neg = 1'b1;
			dmin = -dmin;
		end
		maj = 7'(ma0);
		mnr = 7'(mi0);
		mend = 7'(ma1);
		err = 2 * dmin - dmaj;
		n = 0;
		forever begin
			last = (maj >= mend);
			px = steep ? mnr : maj;
			py = steep ? maj : mnr;
			in_frame = (px < frame_w) && (py < frame_h);
			pix.pixel_x = 6'(px);
			pix.pixel_y = 6'(py);
			pix.pixel_index = in_frame ? 12'(py * frame_w + px) : '0;
			pix.packed_color = {w.red, w.green, w.blue};
			pix.write_enable = in_frame;
			pix.last_pixel = last;
			expected_pixels.push_back(pix);
			n++;
			if (err > 0) begin
				mnr = neg ? mnr - 7'd1 : mnr + 7'd1;
				err += 2 * (dmin - dmaj);
			end else begin
				err += 2 * dmin;
			end
			if (last || n >= 64)
				break;
			maj = maj + 7'd1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t exp;
		if (!arst_n) begin
			frame_w = 7'd64;
			frame_h = 7'd64;
			expected_pixels.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					note_mismatch("unexpected pixel", '0, 64'(out_word));
				end else begin
					exp = expected_pixels.pop_front();
					if (out_word.pixel_x !== exp.pixel_x || out_word.pixel_y !== exp.pixel_y
							|| out_word.pixel_index !== exp.pixel_index
							|| out_word.packed_color !== exp.packed_color
							|| out_word.write_enable !== exp.write_enable
							|| out_word.last_pixel !== exp.last_pixel)
						note_mismatch("pixel", 64'(exp), 64'(out_word));
				end
			end
			if (in_valid && !in_stall)
				rasterize_line(in_word);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == AddrWidth)
						frame_w = pwdata[SizeW-1:0];
					else if (paddr == AddrHeight)
						frame_h = pwdata[SizeW-1:0];
				end else if (paddr == AddrWidth) begin
					if (prdata[SizeW-1:0] !== frame_w)
						note_mismatch("frame_width read", 64'(frame_w), 64'(prdata));
				end else if (paddr == AddrHeight) begin
					if (prdata[SizeW-1:0] !== frame_h)
						note_mismatch("frame_height read", 64'(frame_h), 64'(prdata));
				end
			end
		end
		pending = expected_pixels.size();
	end

endmodule
`default_nettype wire

// ===== bench/bresenham_line_rasterizer_top_tb.sv =====
`default_nettype none
module bresenham_line_rasterizer_top_tb;
	import brl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 3000;
	localparam logic [2:0] AddrWidth  = {RegFrameWidth, 2'b00};
	localparam logic [2:0] AddrHeight = {RegFrameHeight, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_word;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int errors;
	int pending;
	int idle_cycles;
	bit quiet;

	bresenham_line_rasterizer_top dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .in_word,
		.out_valid, .out_stall, .out_word,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	brl_checker checker_i (
		.clk, .arst_n,
		.in_valid, .in_stall, .in_word,
		.out_valid, .out_stall, .out_word,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.errors, .pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_wait();
		if (quiet || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	function automatic in_word_t make_line(int x0, int y0, int x1, int y1, logic [23:0] rgb);
		in_word_t w;
		w.start_x = 6'(x0);
		w.start_y = 6'(y0);
		w.end_x = 6'(x1);
		w.end_y = 6'(y1);
		{w.red, w.green, w.blue} = rgb;
		return w;
	endfunction

	function automatic int clip63(int v);
		return (v < 0) ? 0 : (v > 63) ? 63 : v;
	endfunction

	function automatic in_word_t random_line();
		int x0, y0, x1, y1, span;
		x0 = $urandom_range(0, 63);
		y0 = $urandom_range(0, 63);
		case ($urandom_range(0, 9))
			6, 7: begin
				x1 = clip63(x0 + $urandom_range(0, 14) - 7);
				y1 = clip63(y0 + $urandom_range(0, 14) - 7);
			end
			8: begin
				if ($urandom_range(0, 1)) begin
					x1 = $urandom_range(0, 63); y1 = y0;
				end else begin
					x1 = x0; y1 = $urandom_range(0, 63);
				end
			end
			9: begin
				span = $urandom_range(0, 20);
				x1 = clip63(x0 + ($urandom_range(0, 1) ? span : -span));
				y1 = clip63(y0 + ($urandom_range(0, 1) ? span : -span));
			end
			default: begin
				x1 = $urandom_range(0, 63);
				y1 = $urandom_range(0, 63);
			end
		endcase
		return make_line(x0, y0, x1, y1, 24'($urandom()));
	endfunction

	// valid stays high across back-to-back words, lowered only for a gap
	task automatic send_line(in_word_t w);
		int gap;
		gap = pick_wait();
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain_lines();
		@(negedge clk) in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_access(bit wr, logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk) penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_frame(int w, int h);
		apb_access(1'b1, AddrWidth, ($urandom() & ~32'h7f) | 32'(w));
		apb_access(1'b1, AddrHeight, ($urandom() & ~32'h7f) | 32'(h));
		apb_access(1'b0, AddrWidth, 32'($urandom()));
		apb_access(1'b0, AddrHeight, 32'($urandom()));
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			repeat (pick_wait()) @(negedge clk) out_stall <= 1'b1;
			@(negedge clk) out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int widths[6];
		int heights[6];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_cycles = 0;
		quiet = 1'b0;
		widths = '{1, 127, 0, 40, 64, 0};
		heights = '{64, 127, 30, 0, 1, 0};
		widths[5] = $urandom_range(1, 127);
		heights[5] = $urandom_range(1, 127);
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset frame of 64 by 64
		send_line(make_line(0, 0, 0, 0, 24'h000000));
		send_line(make_line(63, 63, 63, 63, 24'hffffff));
		send_line(make_line(0, 0, 63, 0, 24'haa55aa));
		send_line(make_line(63, 0, 0, 0, 24'h55aa55));
		send_line(make_line(0, 63, 0, 0, 24'hff0000));
		send_line(make_line(63, 0, 63, 63, 24'h00ff00));
		send_line(make_line(0, 0, 63, 63, 24'h0000ff));
		send_line(make_line(63, 0, 0, 63, 24'h123456));
		send_line(make_line(63, 63, 0, 0, 24'h808080));
		send_line(make_line(10, 10, 40, 20, 24'h7f7f7f));
		send_line(make_line(40, 20, 10, 10, 24'h010101));
		send_line(make_line(10, 20, 40, 10, 24'hfedcba));
		send_line(make_line(20, 10, 25, 50, 24'h0f0f0f));
		send_line(make_line(25, 50, 20, 10, 24'hf0f0f0));
		send_line(make_line(30, 5, 5, 40, 24'h336699));
		send_line(make_line(5, 5, 9, 4, 24'h996633));
		send_line(make_line(7, 3, 8, 4, 24'hc0ffee));
		send_line(make_line(2, 7, 3, 7, 24'h00ffff));
		send_line(make_line(0, 63, 63, 62, 24'hff00ff));
		send_line(make_line(62, 0, 63, 63, 24'hffff00));
		drain_lines();

		for (int p = 0; p < 6; p++) begin
			set_frame(widths[p], heights[p]);
			quiet = (p == 2);
			for (int i = 0; i < 17; i++) begin
				if (p == 1 && i == 8)
					drain_lines();
				if (p == 2 && i == 0)
					send_line(make_line(0, 0, 63, 63, 24'h5a5a5a));
				else
					send_line(random_line());
			end
			drain_lines();
		end
		quiet = 1'b0;

		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
